// File: rtl/rplt_pkg.sv
// ----------------------------------------------------------------------------
// Route prefix lookup table package
// Shared types, codes and constants of the route table cell chain.
// ----------------------------------------------------------------------------
package rplt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int V4_BITS = 32;
	localparam int V6_BITS = 128;
	localparam int V4_PAD = V6_BITS - V4_BITS;

	localparam int FLG_ADDR = 0;
	localparam int FLG_MASK = 1;
	localparam int FLG_GW = 2;
	localparam int FLG_SCOPE = 3;

	typedef enum logic [1:0] {
		K_CLEAR = 2'd0,
		K_INSERT = 2'd1,
		K_LOOKUP = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_INS = 2'd1,
		OP_LOOK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0] len;
		logic [3:0] flags;
		logic [15:0] ifx;
	} entry_t;

	typedef struct packed {
		logic vld;
		op_t op;
		logic v6;
		logic [63:0] ahi;
		logic [63:0] alo;
		entry_t ent;
		logic shift;
		logic done;
		logic hit;
		logic dhit;
		logic [15:0] found;
		logic [15:0] dflt;
		status_t status;
	} tok_t;

endpackage

// File: rtl/rplt_cell.sv
// ----------------------------------------------------------------------------
// Route table cell
// Holds one sorted slot of each family table and works on the beat passing by.
// ----------------------------------------------------------------------------
module rplt_cell #(
	parameter int IDX = 0,
	parameter int CW = 7
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input rplt_pkg::tok_t tok_i,
	input logic [CW-1:0] cnt_i,
	output rplt_pkg::tok_t tok_o,
	output logic [CW-1:0] cnt_o
);
	import rplt_pkg::*;

	entry_t ent_q [2];
	tok_t tok_q;
	logic vld_q;
	logic [CW-1:0] cnt_q;
	tok_t nt;
	entry_t e;
	logic wr;
	logic occ;
	logic stays;
	logic [7:0] lenx;
	logic [127:0] mask;
	logic match;
	logic dcand;

	always_comb begin
		e = ent_q[tok_i.v6];
		nt = tok_i;
		wr = 1'b0;
		occ = CW'(IDX) < cnt_i;
		stays = (e.len > tok_i.ent.len) || ((e.len == tok_i.ent.len) &&
			(!e.flags[FLG_SCOPE] || tok_i.ent.flags[FLG_SCOPE]));
		lenx = tok_i.v6 ? e.len : e.len + 8'(V4_PAD);
		mask = ~({128{1'b1}} >> lenx);
		match = ((({e.hi, e.lo} ^ {tok_i.ahi, tok_i.alo}) & mask) == 128'd0) &&
			(e.ifx != 16'd0) && e.flags[FLG_MASK];
		dcand = (!e.flags[FLG_ADDR] || ((e.hi == 64'd0) && (e.lo == 64'd0))) &&
			(!e.flags[FLG_MASK] || (e.len == 8'd0)) && e.flags[FLG_GW];
		if (tok_i.vld && (tok_i.op == OP_INS) && !tok_i.done) begin
			if (occ) begin
				if (tok_i.shift || !stays) begin
					wr = 1'b1;
					nt.ent = e;
					nt.shift = 1'b1;
				end
			end else begin
				wr = 1'b1;
				nt.done = 1'b1;
			end
		end
		if (tok_i.vld && (tok_i.op == OP_LOOK) && occ) begin
			if (!tok_i.hit && match) begin
				nt.hit = 1'b1;
				nt.found = e.ifx;
			end
			if (!tok_i.dhit && dcand) begin
				nt.dhit = 1'b1;
				nt.dflt = e.ifx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr) begin
			ent_q[tok_i.v6] <= tok_i.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= tok_i.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_q <= nt;
			cnt_q <= cnt_i;
		end
	end

	always_comb begin
		tok_o = tok_q;
		tok_o.vld = vld_q;
	end

	assign cnt_o = cnt_q;

endmodule

// File: rtl/route_prefix_lookup_table_top.sv
// ----------------------------------------------------------------------------
// Route prefix lookup table
// Per-family route tables sorted longest prefix first, held in a cell chain.
// ----------------------------------------------------------------------------
// Input beats arrive on s_tvalid/s_tready; s_tuser carries the item kind and
// the address family, s_tdata the route or destination. Each input beat gives
// exactly one output beat on m_tvalid/m_tready with the status, the resolved
// interface and the default-route flag.
// Every beat walks a chain of TABLE_ENTRIES cells and then lands in the
// output register. A new beat is taken every cycle while the output is not
// held by m_tready, so throughput is one item per cycle; inserts and lookups
// may follow each other freely since a later beat always meets each cell
// after the earlier one has left it.
// The chain length is set by the table depth: the k-th cell holds the k-th
// sorted slot of both families.
// Reset empties both tables by clearing their entry counts and drops any beat
// in flight; no clearing pass runs. While the output beat waits on m_tready
// the whole chain holds and s_tready is low.
module route_prefix_lookup_table_top #(
	parameter int TABLE_ENTRIES = rplt_pkg::TABLE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// addr_high, addr_low, addr_valid, mask_valid, prefix_len, gateway_valid,
	// if_index, if_scoped, zero pad
	input logic [159:0] s_tdata,
	// kind, is_v6
	input logic [2:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// status, found_index, zero pad
	output logic [23:0] m_tdata,
	// from_default
	output logic [0:0] m_tuser
);
	import rplt_pkg::*;

	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic adv;
	logic acc;
	logic [CW-1:0] cnt_q [2];
	logic fam;
	logic full;
	logic [63:0] ahi;
	logic [63:0] alo;
	logic [7:0] maxlen;
	logic [7:0] plen;
	tok_t tok_s [TABLE_ENTRIES+1];
	logic [CW-1:0] cnt_s [TABLE_ENTRIES+1];
	tok_t tl;
	status_t r_status;
	logic [15:0] r_found;
	logic r_def;
	status_t status_q;
	logic [15:0] found_q;
	logic def_q;
	logic valid_q;

	assign adv = !valid_q || m_tready;
	assign s_tready = adv;
	assign acc = s_tvalid && adv;
	assign fam = s_tuser[2];
	assign full = cnt_q[fam] >= CW'(TABLE_ENTRIES);

	always_comb begin
		ahi = fam ? s_tdata[63:0] : 64'd0;
		alo = fam ? s_tdata[127:64] : {32'd0, s_tdata[95:64]};
		maxlen = fam ? 8'(V6_BITS) : 8'(V4_BITS);
		plen = (s_tdata[137:130] > maxlen) ? maxlen : s_tdata[137:130];
		tok_s[0] = '0;
		tok_s[0].vld = acc;
		tok_s[0].v6 = fam;
		tok_s[0].ahi = ahi;
		tok_s[0].alo = alo;
		tok_s[0].ent.hi = s_tdata[128] ? ahi : 64'd0;
		tok_s[0].ent.lo = s_tdata[128] ? alo : 64'd0;
		tok_s[0].ent.len = s_tdata[129] ? plen : 8'd0;
		tok_s[0].ent.flags = {s_tdata[155], s_tdata[138], s_tdata[129], s_tdata[128]};
		tok_s[0].ent.ifx = s_tdata[154:139];
		tok_s[0].op = OP_NONE;
		tok_s[0].status = ST_OK;
		unique case (kind_t'(s_tuser[1:0]))
			K_CLEAR: begin
				tok_s[0].op = OP_NONE;
			end
			K_INSERT: begin
				if (full) begin
					tok_s[0].status = ST_FULL;
				end else begin
					tok_s[0].op = OP_INS;
				end
			end
			K_LOOKUP: begin
				tok_s[0].op = OP_LOOK;
			end
			default: begin
				tok_s[0].op = OP_NONE;
			end
		endcase
		cnt_s[0] = cnt_q[fam];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
		end else if (acc) begin
			if (s_tuser[1:0] == K_CLEAR) begin
				cnt_q[fam] <= '0;
			end else if ((s_tuser[1:0] == K_INSERT) && !full) begin
				cnt_q[fam] <= cnt_q[fam] + 1'b1;
			end
		end
	end

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		rplt_cell #(
			.IDX(g),
			.CW(CW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.tok_i(tok_s[g]),
			.cnt_i(cnt_s[g]),
			.tok_o(tok_s[g+1]),
			.cnt_o(cnt_s[g+1])
		);
	end

	assign tl = tok_s[TABLE_ENTRIES];

	always_comb begin
		r_status = tl.status;
		r_found = 16'd0;
		r_def = 1'b0;
		if (tl.op == OP_LOOK) begin
			if (tl.hit) begin
				r_found = tl.found;
			end else if (tl.dhit) begin
				r_found = tl.dflt;
				r_def = tl.dflt != 16'd0;
			end
			r_status = (r_found != 16'd0) ? ST_OK : ST_MISS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= tl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= r_status;
			found_q <= r_found;
			def_q <= r_def;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {6'd0, found_q, status_q};
	assign m_tuser = def_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= CW'(TABLE_ENTRIES)) && (cnt_q[1] <= CW'(TABLE_ENTRIES)))
		else $error("route count beyond table depth");

	a_def_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> ((m_tdata[1:0] == ST_OK) && (m_tdata[17:2] != 16'd0)))
		else $error("default answer without an interface");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (s_tuser[1:0] == K_INSERT) && !full) |=>
		(cnt_q[$past(fam)] == $past(cnt_q[fam]) + 1'b1))
		else $error("insert did not grow the table");

	a_clr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (s_tuser[1:0] == K_CLEAR)) |=> (cnt_q[$past(fam)] == '0))
		else $error("clear left entries behind");

endmodule
